@@ hw/rtl/rotation_matrix_to_quaternion_macros.svh @@
// Assertion macros used by the rotation matrix to quaternion top level
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define RMQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rmq: implication failed");
// Next-cycle implication, checked out of reset
`define RMQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rmq: next-cycle implication failed");
`else
`define RMQ_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RMQ_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ hw/rtl/rmq_pkg.sv @@
// Types and constants of the rotation matrix to quaternion pipeline
package rmq_pkg;
  localparam int QW  = 16;        // Q2.14 field width
  localparam int NW  = 17;        // off-diagonal sum or difference
  localparam int CW  = 19;        // candidate width
  localparam int RW  = 15;        // square root width
  localparam int XW  = 2 * RW;    // radicand width
  localparam int RMW = RW + 3;    // root remainder width
  localparam int DW  = 29;        // dividend width
  localparam int QB  = 16;        // quotient bits
  localparam int DIV_LAT = QB + 2;

  localparam logic signed [CW-1:0] ONE_Q14 = 19'sd16384;
  localparam logic signed [QW-1:0] QMAX = 16'sh7FFF;
  localparam logic signed [QW-1:0] QMIN = 16'sh8000;

  localparam logic [1:0] BR_W = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;

  typedef struct packed {
    logic signed [QW-1:0] m00;
    logic signed [QW-1:0] m01;
    logic signed [QW-1:0] m02;
    logic signed [QW-1:0] m10;
    logic signed [QW-1:0] m11;
    logic signed [QW-1:0] m12;
    logic signed [QW-1:0] m20;
    logic signed [QW-1:0] m21;
    logic signed [QW-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic [1:0]           branch;
    logic                 degenerate;
  } out_t;

  // Branch control and the three numerators, in w x y z order less the chosen one
  typedef struct packed {
    logic [1:0]           sel;
    logic                 degen;
    logic signed [NW-1:0] n0;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
  } side_t;

  typedef struct packed {
    logic [1:0]    sel;
    logic          degen;
    logic [RW-1:0] root;
  } ctl_t;
endpackage

@@ hw/rtl/rmq_prep.sv @@
// Candidate forming, branch pick and numerator selection
module rmq_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  rmq_pkg::in_t          in_data,
  output logic                  v_r,
  output logic [rmq_pkg::XW-1:0] x_r,
  output rmq_pkg::side_t        side_r
);
  localparam int CW = rmq_pkg::CW;
  localparam int QW = rmq_pkg::QW;
  localparam int NW = rmq_pkg::NW;

  logic signed [CW-1:0] e00, e11, e22, tr, c0, c1, c2, c3, best;
  logic signed [NW-1:0] a01, a02, a10, a12, a20, a21;
  logic signed [NW-1:0] d1, d2, d3, s_xy, s_xz, s_yz;
  logic [1:0] sel;
  rmq_pkg::side_t side_nxt;
  logic [rmq_pkg::XW-1:0] x_nxt;

  // Extend the entries
  assign e00 = {{(CW-QW){in_data.m00[QW-1]}}, in_data.m00};
  assign e11 = {{(CW-QW){in_data.m11[QW-1]}}, in_data.m11};
  assign e22 = {{(CW-QW){in_data.m22[QW-1]}}, in_data.m22};
  assign a01 = {in_data.m01[QW-1], in_data.m01};
  assign a02 = {in_data.m02[QW-1], in_data.m02};
  assign a10 = {in_data.m10[QW-1], in_data.m10};
  assign a12 = {in_data.m12[QW-1], in_data.m12};
  assign a20 = {in_data.m20[QW-1], in_data.m20};
  assign a21 = {in_data.m21[QW-1], in_data.m21};

  // Form the four candidates
  assign tr = e00 + e11 + e22;
  assign c0 = rmq_pkg::ONE_Q14 + tr;
  assign c1 = rmq_pkg::ONE_Q14 + e00 - e11 - e22;
  assign c2 = rmq_pkg::ONE_Q14 + e11 - e00 - e22;
  assign c3 = rmq_pkg::ONE_Q14 + e22 - e00 - e11;

  // Off-diagonal sums and differences
  assign d1   = a21 - a12;
  assign d2   = a02 - a20;
  assign d3   = a10 - a01;
  assign s_xy = a10 + a01;
  assign s_xz = a02 + a20;
  assign s_yz = a21 + a12;

  // Pick the largest, earliest wins a tie
  always_comb begin
    best = c0;
    sel  = rmq_pkg::BR_W;
    if (c1 > best) begin
      best = c1;
      sel  = rmq_pkg::BR_X;
    end
    if (c2 > best) begin
      best = c2;
      sel  = rmq_pkg::BR_Y;
    end
    if (c3 > best) begin
      best = c3;
      sel  = rmq_pkg::BR_Z;
    end
  end

  // Route numerators and scale the radicand by 4096
  always_comb begin
    side_nxt.sel   = sel;
    side_nxt.degen = (best <= 0);
    case (sel)
      rmq_pkg::BR_W: begin
        side_nxt.n0 = d1;
        side_nxt.n1 = d2;
        side_nxt.n2 = d3;
      end
      rmq_pkg::BR_X: begin
        side_nxt.n0 = d1;
        side_nxt.n1 = s_xy;
        side_nxt.n2 = s_xz;
      end
      rmq_pkg::BR_Y: begin
        side_nxt.n0 = d2;
        side_nxt.n1 = s_xy;
        side_nxt.n2 = s_yz;
      end
      default: begin
        side_nxt.n0 = d3;
        side_nxt.n1 = s_xz;
        side_nxt.n2 = s_yz;
      end
    endcase
    if (best <= 0) begin
      x_nxt = '0;
    end else begin
      x_nxt = {1'b0, best[16:0], 12'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      side_r <= side_nxt;
    end
  end
endmodule

@@ hw/rtl/rmq_sqrt.sv @@
// Pipelined rounded square root, one root bit per stage, side data carried along
module rmq_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_in,
  input  logic [rmq_pkg::XW-1:0] x_in,
  input  rmq_pkg::side_t         side_in,
  output logic                   v_out,
  output logic [rmq_pkg::RW-1:0] root_out,
  output rmq_pkg::side_t         side_out
);
  localparam int RW  = rmq_pkg::RW;
  localparam int XW  = rmq_pkg::XW;
  localparam int RMW = rmq_pkg::RMW;

  logic [RW-1:0]  v_r;
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [XW-1:0]  xs_r   [RW];
  rmq_pkg::side_t sd_r   [RW];
  logic           vo_r;
  logic [RW-1:0]  ro_r;
  rmq_pkg::side_t so_r;

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic           v_i;
    logic [RMW-1:0] rem_i, rem_sh, trial, diff;
    logic [RW-1:0]  root_i;
    logic [XW-1:0]  xs_i;
    rmq_pkg::side_t sd_i;
    logic           ge;

    if (i == 0) begin : g_first
      assign v_i    = v_in;
      assign rem_i  = '0;
      assign root_i = '0;
      assign xs_i   = x_in;
      assign sd_i   = side_in;
    end else begin : g_next
      assign v_i    = v_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign root_i = root_r[i-1];
      assign xs_i   = xs_r[i-1];
      assign sd_i   = sd_r[i-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_i[RMW-3:0], xs_i[XW-1 -: 2]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff : rem_sh;
        root_r[i] <= {root_i[RW-2:0], ge};
        xs_r[i]   <= {xs_i[XW-3:0], 2'b00};
        sd_r[i]   <= sd_i;
      end
    end
  end

  // Round to nearest: add one when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ro_r <= (rem_r[RW-1] > {3'b000, root_r[RW-1]}) ? root_r[RW-1] + 1'b1 : root_r[RW-1];
      so_r <= sd_r[RW-1];
    end
  end

  assign v_out    = vo_r;
  assign root_out = ro_r;
  assign side_out = so_r;
endmodule

@@ hw/rtl/rmq_div.sv @@
// Pipelined signed divide of n*4096 by the root, rounded away from zero and saturated
module rmq_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rmq_pkg::NW-1:0] n_in,
  input  logic [rmq_pkg::RW-1:0]        c_in,
  output logic signed [rmq_pkg::QW-1:0] q_out
);
  localparam int NW = rmq_pkg::NW;
  localparam int RW = rmq_pkg::RW;
  localparam int DW = rmq_pkg::DW;
  localparam int QB = rmq_pkg::QB;
  localparam int QW = rmq_pkg::QW;

  logic          neg;
  logic [NW-1:0] mag;
  logic [DW-1:0] dvd;
  logic          ovf;

  logic          neg_s_r, ovf_s_r;
  logic [RW-1:0] c_s_r, rem_s_r;
  logic [QB-1:0] dl_s_r;

  logic          neg_r [QB];
  logic          ovf_r [QB];
  logic [RW-1:0] c_r   [QB];
  logic [RW-1:0] rem_r [QB];
  logic [QB-1:0] dl_r  [QB];
  logic [QB-1:0] q_r   [QB];

  logic signed [QW-1:0] res;
  logic signed [QW-1:0] q_o_r;

  // Set up magnitude, rounding bias and the overflow check
  assign neg = n_in[NW-1];
  assign mag = neg ? NW'(-n_in) : NW'(n_in);
  assign dvd = {mag, 12'b0} + DW'(c_in >> 1);
  assign ovf = ({2'b00, dvd[DW-1:QB]} >= c_in);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s_r <= neg;
      ovf_s_r <= ovf;
      c_s_r   <= c_in;
      rem_s_r <= {2'b00, dvd[DW-1:QB]};
      dl_s_r  <= dvd[QB-1:0];
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic          neg_i, ovf_i, ge;
    logic [RW-1:0] c_i, rem_i;
    logic [QB-1:0] dl_i, q_i;
    logic [RW:0]   r_sh, diff;

    if (i == 0) begin : g_first
      assign neg_i = neg_s_r;
      assign ovf_i = ovf_s_r;
      assign c_i   = c_s_r;
      assign rem_i = rem_s_r;
      assign dl_i  = dl_s_r;
      assign q_i   = '0;
    end else begin : g_next
      assign neg_i = neg_r[i-1];
      assign ovf_i = ovf_r[i-1];
      assign c_i   = c_r[i-1];
      assign rem_i = rem_r[i-1];
      assign dl_i  = dl_r[i-1];
      assign q_i   = q_r[i-1];
    end

    // Shift in one dividend bit and subtract where it fits
    assign r_sh = {rem_i, dl_i[QB-1]};
    assign ge   = (r_sh >= {1'b0, c_i});
    assign diff = r_sh - {1'b0, c_i};

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i] <= neg_i;
        ovf_r[i] <= ovf_i;
        c_r[i]   <= c_i;
        rem_r[i] <= ge ? diff[RW-1:0] : r_sh[RW-1:0];
        dl_r[i]  <= {dl_i[QB-2:0], 1'b0};
        q_r[i]   <= {q_i[QB-2:0], ge};
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    if (ovf_r[QB-1]) begin
      res = neg_r[QB-1] ? rmq_pkg::QMIN : rmq_pkg::QMAX;
    end else if (neg_r[QB-1]) begin
      res = q_r[QB-1][QB-1] ? rmq_pkg::QMIN : QW'(-q_r[QB-1]);
    end else begin
      res = q_r[QB-1][QB-1] ? rmq_pkg::QMAX : QW'(q_r[QB-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o_r <= res;
    end
  end

  assign q_out = q_o_r;
endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to quaternion, top level
// Converts one 3x3 rotation matrix of Q2.14 entries to a unit quaternion by
// Shepperd's method. The block takes one matrix per clock cycle unless stalled.
// Each result passes through the candidate and branch pick register, the
// square root (one root bit per stage plus rounding), the three parallel
// dividers (one quotient bit per stage plus setup and saturation) and the
// output register. A stall on a valid output beat freezes the whole
// pipeline and holds in_stall high.
`include "rotation_matrix_to_quaternion_macros.svh"
module rotation_matrix_to_quaternion (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rmq_pkg::out_t out_data
);
  localparam int QW  = rmq_pkg::QW;
  localparam int LAT = rmq_pkg::DIV_LAT;

  logic en;
  logic pr_v;
  logic [rmq_pkg::XW-1:0] pr_x;
  rmq_pkg::side_t pr_side;
  logic sq_v;
  logic [rmq_pkg::RW-1:0] sq_root;
  rmq_pkg::side_t sq_side;
  rmq_pkg::ctl_t  sq_ctl;
  logic signed [QW-1:0] q0, q1, q2;

  logic [LAT-1:0] dv_r;
  rmq_pkg::ctl_t  dctl_r [LAT];

  logic signed [QW-1:0] cc, w, x, y, z;
  rmq_pkg::out_t out_nxt;
  rmq_pkg::out_t out_data_r;
  logic out_valid_r;

  // Advance every stage unless the output beat is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = out_valid_r && out_stall;

  rmq_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .v_r      (pr_v),
    .x_r      (pr_x),
    .side_r   (pr_side)
  );

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (pr_v),
    .x_in     (pr_x),
    .side_in  (pr_side),
    .v_out    (sq_v),
    .root_out (sq_root),
    .side_out (sq_side)
  );

  rmq_div u_div0 (.clk(clk), .en(en), .n_in(sq_side.n0), .c_in(sq_root), .q_out(q0));
  rmq_div u_div1 (.clk(clk), .en(en), .n_in(sq_side.n1), .c_in(sq_root), .q_out(q1));
  rmq_div u_div2 (.clk(clk), .en(en), .n_in(sq_side.n2), .c_in(sq_root), .q_out(q2));

  assign sq_ctl.sel   = sq_side.sel;
  assign sq_ctl.degen = sq_side.degen;
  assign sq_ctl.root  = sq_root;

  // Carry valid and branch control alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[LAT-2:0], sq_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dctl_r[0] <= sq_ctl;
      for (int k = 1; k < LAT; k++) begin
        dctl_r[k] <= dctl_r[k-1];
      end
    end
  end

  // Place components, fix the sign, clear degenerate results
  assign cc = {1'b0, dctl_r[LAT-1].root};

  always_comb begin
    case (dctl_r[LAT-1].sel)
      rmq_pkg::BR_W: begin
        w = cc; x = q0; y = q1; z = q2;
      end
      rmq_pkg::BR_X: begin
        w = q0; x = cc; y = q1; z = q2;
      end
      rmq_pkg::BR_Y: begin
        w = q0; x = q1; y = cc; z = q2;
      end
      default: begin
        w = q0; x = q1; y = q2; z = cc;
      end
    endcase
    out_nxt.branch     = dctl_r[LAT-1].sel;
    out_nxt.degenerate = dctl_r[LAT-1].degen;
    if (dctl_r[LAT-1].degen) begin
      out_nxt.quat_w = '0;
      out_nxt.quat_x = '0;
      out_nxt.quat_y = '0;
      out_nxt.quat_z = '0;
    end else if (w <= 0) begin
      out_nxt.quat_w = (w == rmq_pkg::QMIN) ? rmq_pkg::QMAX : QW'(-w);
      out_nxt.quat_x = (x == rmq_pkg::QMIN) ? rmq_pkg::QMAX : QW'(-x);
      out_nxt.quat_y = (y == rmq_pkg::QMIN) ? rmq_pkg::QMAX : QW'(-y);
      out_nxt.quat_z = (z == rmq_pkg::QMIN) ? rmq_pkg::QMAX : QW'(-z);
    end else begin
      out_nxt.quat_w = w;
      out_nxt.quat_x = x;
      out_nxt.quat_y = y;
      out_nxt.quat_z = z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RMQ_ASSERT_IMP(a_w_nonneg, clk, rst_n, out_valid_r, !out_data_r.quat_w[QW-1])
  `RMQ_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid_r && out_data_r.degenerate, (out_data_r.quat_w == '0) && (out_data_r.quat_x == '0) && (out_data_r.quat_y == '0) && (out_data_r.quat_z == '0))
  `RMQ_ASSERT_IMP(a_trace_w, clk, rst_n, out_valid_r && !out_data_r.degenerate && (out_data_r.branch == rmq_pkg::BR_W), out_data_r.quat_w != '0)
  `RMQ_ASSERT_NXT(a_div_entry, clk, rst_n, sq_v && en, dv_r[0])
endmodule
